// File: rtl/tocf_pkg.sv
package tocf_pkg;

	localparam logic [2:0] ACT_FEED  = 3'd0;
	localparam logic [2:0] ACT_SET   = 3'd1;
	localparam logic [2:0] ACT_CLEAR = 3'd2;
	localparam logic [2:0] ACT_CHECK = 3'd3;
	localparam logic [2:0] ACT_POP   = 3'd4;

	localparam logic [1:0] KIND_SEQ   = 2'd0;
	localparam logic [1:0] KIND_COUNT = 2'd1;

	localparam logic [1:0] MODE_UNSET = 2'd0;
	localparam logic [1:0] MODE_SEQ   = 2'd1;
	localparam logic [1:0] MODE_COUNT = 2'd2;
	localparam logic [1:0] MODE_ANY   = 2'd3;

	localparam int SEQ_VALUE_BYTES = 8;
	localparam int LEN_MAX         = 15;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  data_byte;
		logic [1:0]  term_kind;
		logic [63:0] term_value;
		logic [3:0]  term_len;
		logic [6:0]  term_count;
	} cmd_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last;
		logic       empty_frame;
		logic       overflow;
	} res_t;

endpackage

// File: rtl/tocf_ram.sv
module tocf_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          ren,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (ren) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/terminator_or_count_framer.sv
// Byte framer around a ring store of BUF_DEPTH bytes held in one single-port-read
// memory. Feed, set, clear, check and pop are requests on cmd; each produces zero
// or more results on res, one per frame byte, oldest first, with last on the final
// one. Set and clear complete when accepted. A feed or check with a byte-sequence
// terminator scans the store one byte per cycle through the memory read port;
// count and 'any' terminators decide without a scan. Emitting a frame reads each
// byte from memory, then puts it in the output register, waiting while res is
// stalled. A new request is taken once the previous one is finished; the last
// result may still wait in the output register.
module terminator_or_count_framer #(
	parameter int BUF_DEPTH = 64,
	parameter int MAX_TERM  = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  tocf_pkg::cmd_t cmd,
	output logic          res_valid,
	input  logic          res_stall,
	output tocf_pkg::res_t res
);

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam int FW = $clog2(BUF_DEPTH + 1);
	localparam int CW = (FW > 7) ? FW : 7;
	localparam int SW = AW + 2;
	localparam int WL = (MAX_TERM < tocf_pkg::LEN_MAX) ? MAX_TERM : tocf_pkg::LEN_MAX;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DECIDE, ST_SCAN, ST_EM_RD, ST_EM_DATA, ST_EMPTY, ST_OVF
	} state_t;

	state_t        state_q;
	logic [AW-1:0] rp_q;
	logic [FW-1:0] fill_q;
	logic [1:0]    mode_q;
	logic [63:0]   term_q;
	logic [3:0]    tlen_q;
	logic [6:0]    count_q;
	logic [FW-1:0] len_q;
	logic [FW-1:0] eo_q;
	logic [FW-1:0] si_q;
	logic          rd_vld_s1;
	logic [FW-1:0] off_s1;
	logic [7:0]    win_q [WL];
	logic          res_vld_q;
	tocf_pkg::res_t res_q;

	logic          we, ren;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    rdata;
	logic          accept, out_free, issue, hit;
	logic [7:0]    cw [WL];

	function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base, input logic [FW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(BUF_DEPTH)) begin
			s = s - SW'(BUF_DEPTH);
		end
		return s[AW-1:0];
	endfunction

	function automatic logic [7:0] tbyte(input logic [63:0] t, input int i);
		logic [7:0] b;
		b = 8'd0;
		for (int n = 0; n < tocf_pkg::SEQ_VALUE_BYTES; n++) begin
			if (n == i) begin
				b = t[8*n +: 8];
			end
		end
		return b;
	endfunction

	assign accept    = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != ST_IDLE);
	assign out_free  = !res_vld_q || !res_stall;
	assign res_valid = res_vld_q;
	assign res       = res_q;

	// window as it stands with the returning byte shifted in, newest at 0
	always_comb begin
		cw[0] = rdata;
		for (int k = 1; k < WL; k++) begin
			cw[k] = win_q[k-1];
		end
	end

	always_comb begin
		hit = rd_vld_s1 && (({1'b0, CW'(off_s1)} + (CW+1)'(1)) >= (CW+1)'(tlen_q));
		for (int k = 0; k < WL; k++) begin
			if (k < int'(tlen_q) && cw[k] != tbyte(term_q, int'(tlen_q) - 1 - k)) begin
				hit = 1'b0;
			end
		end
	end

	assign issue = (state_q == ST_SCAN) && (si_q < fill_q) && !hit;
	assign we    = accept && (cmd.action == tocf_pkg::ACT_FEED) && (fill_q != FW'(BUF_DEPTH));
	assign waddr = wrap(rp_q, fill_q);

	always_comb begin
		ren   = 1'b0;
		raddr = wrap(rp_q, eo_q);
		if (issue) begin
			ren   = 1'b1;
			raddr = wrap(rp_q, si_q);
		end else if (state_q == ST_EM_RD) begin
			ren = 1'b1;
		end
	end

	tocf_ram #(.DEPTH(BUF_DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (cmd.data_byte),
		.ren   (ren),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			for (int k = 0; k < WL; k++) begin
				win_q[k] <= cw[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rp_q      <= '0;
			fill_q    <= '0;
			mode_q    <= tocf_pkg::MODE_UNSET;
			term_q    <= '0;
			tlen_q    <= '0;
			count_q   <= '0;
			len_q     <= '0;
			eo_q      <= '0;
			si_q      <= '0;
			rd_vld_s1 <= 1'b0;
			off_s1    <= '0;
			res_vld_q <= 1'b0;
			res_q     <= '0;
		end else begin
			rd_vld_s1 <= issue;
			off_s1    <= si_q;
			if (issue) begin
				si_q <= si_q + FW'(1);
			end
			if (res_vld_q && !res_stall) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.action)
							tocf_pkg::ACT_FEED: begin
								if (fill_q == FW'(BUF_DEPTH)) begin
									state_q <= ST_OVF;
								end else begin
									fill_q  <= fill_q + FW'(1);
									state_q <= ST_DECIDE;
								end
							end
							tocf_pkg::ACT_SET: begin
								if (cmd.term_kind == tocf_pkg::KIND_SEQ) begin
									mode_q <= tocf_pkg::MODE_SEQ;
									term_q <= cmd.term_value;
									tlen_q <= (32'(cmd.term_len) > MAX_TERM) ? 4'(MAX_TERM)
									          : cmd.term_len;
								end else if (cmd.term_kind == tocf_pkg::KIND_COUNT) begin
									mode_q  <= tocf_pkg::MODE_COUNT;
									count_q <= cmd.term_count;
								end else begin
									mode_q <= tocf_pkg::MODE_ANY;
								end
							end
							tocf_pkg::ACT_CLEAR: begin
								mode_q  <= tocf_pkg::MODE_UNSET;
								term_q  <= '0;
								tlen_q  <= '0;
								count_q <= '0;
							end
							tocf_pkg::ACT_CHECK: begin
								state_q <= ST_DECIDE;
							end
							tocf_pkg::ACT_POP: begin
								if (fill_q != '0) begin
									len_q   <= fill_q;
									eo_q    <= '0;
									state_q <= ST_EM_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DECIDE: begin
					state_q <= ST_IDLE;
					eo_q    <= '0;
					case (mode_q)
						tocf_pkg::MODE_SEQ: begin
							if (tlen_q == '0) begin
								state_q <= ST_EMPTY;
							end else if (CW'(tlen_q) <= CW'(fill_q)) begin
								si_q    <= '0;
								state_q <= ST_SCAN;
							end
						end
						tocf_pkg::MODE_COUNT: begin
							if (CW'(fill_q) >= CW'(count_q)) begin
								if (count_q == '0) begin
									state_q <= ST_EMPTY;
								end else begin
									len_q   <= FW'(count_q);
									state_q <= ST_EM_RD;
								end
							end
						end
						tocf_pkg::MODE_ANY: begin
							if (fill_q != '0) begin
								len_q   <= fill_q;
								state_q <= ST_EM_RD;
							end
						end
						default: begin
						end
					endcase
					// any frame found disarms the terminator
					if ((mode_q == tocf_pkg::MODE_SEQ && tlen_q == '0)
					    || (mode_q == tocf_pkg::MODE_COUNT && CW'(fill_q) >= CW'(count_q))
					    || (mode_q == tocf_pkg::MODE_ANY && fill_q != '0)) begin
						mode_q  <= tocf_pkg::MODE_UNSET;
						term_q  <= '0;
						tlen_q  <= '0;
						count_q <= '0;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						len_q   <= off_s1 + FW'(1);
						eo_q    <= '0;
						mode_q  <= tocf_pkg::MODE_UNSET;
						term_q  <= '0;
						tlen_q  <= '0;
						count_q <= '0;
						state_q <= ST_EM_RD;
					end else if (rd_vld_s1 && off_s1 == fill_q - FW'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_DATA;
				end
				ST_EM_DATA: begin
					if (out_free) begin
						res_vld_q         <= 1'b1;
						res_q.frame_byte  <= rdata;
						res_q.last        <= (eo_q == len_q - FW'(1));
						res_q.empty_frame <= 1'b0;
						res_q.overflow    <= 1'b0;
						if (eo_q == len_q - FW'(1)) begin
							fill_q  <= fill_q - len_q;
							rp_q    <= (fill_q == len_q) ? '0 : wrap(rp_q, len_q);
							state_q <= ST_IDLE;
						end else begin
							eo_q    <= eo_q + FW'(1);
							state_q <= ST_EM_RD;
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						res_vld_q <= 1'b1;
						res_q     <= '{frame_byte: 8'd0, last: 1'b1, empty_frame: 1'b1,
						              overflow: 1'b0};
						state_q   <= ST_IDLE;
					end
				end
				ST_OVF: begin
					if (out_free) begin
						res_vld_q <= 1'b1;
						res_q     <= '{frame_byte: 8'd0, last: 1'b1, empty_frame: 1'b0,
						              overflow: 1'b1};
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(fill_q) <= CW'(BUF_DEPTH))
		else $error("fill level above store depth");
	a_empty_rp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && fill_q == '0) |-> rp_q == '0)
		else $error("read pointer not rewound on empty store");
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && (res_q.empty_frame || res_q.overflow)) |-> res_q.last)
		else $error("marker result without last");
	a_scan_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (mode_q == tocf_pkg::MODE_SEQ && tlen_q != '0))
		else $error("scan without sequence terminator");
	a_emit_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EM_RD) |-> (len_q != '0 && len_q <= fill_q && eo_q < len_q))
		else $error("emit length out of range");
`endif

endmodule

// File: verif/terminator_or_count_framer_test.sv
module terminator_or_count_framer_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 64;
	localparam int MAX_TERM = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	tocf_pkg::cmd_t cmd = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	tocf_pkg::res_t res;

	terminator_or_count_framer uut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always #2 clk = ~clk;

	tocf_pkg::cmd_t pending_cmds[$];
	tocf_pkg::res_t frame_expect[$];
	int errors = 0;
	int accepted = 0;
	int got_results = 0;
	int frames_seen = 0;
	int overflows_seen = 0;
	int empties_seen = 0;
	bit gen_done = 0;
	int hold_left = 0;
	bit hold_done = 0;

	// shadow state of the framer
	logic [7:0] shadow_store[DEPTH];
	int shadow_rp = 0;
	int shadow_fill = 0;
	logic [1:0] shadow_mode = tocf_pkg::MODE_UNSET;
	logic [63:0] shadow_term = '0;
	int shadow_tlen = 0;
	int shadow_cnt = 0;

	function automatic void push_frame(int n);
		tocf_pkg::res_t r;
		if (n == 0) begin
			r = '0;
			r.last = 1'b1;
			r.empty_frame = 1'b1;
			frame_expect.push_back(r);
			return;
		end
		for (int i = 0; i < n; i++) begin
			r = '0;
			r.frame_byte = shadow_store[(shadow_rp + i) % DEPTH];
			r.last = (i == n - 1);
			frame_expect.push_back(r);
		end
		shadow_rp = (shadow_rp + n) % DEPTH;
		shadow_fill -= n;
		if (shadow_fill == 0)
			shadow_rp = 0;
	endfunction

	function automatic void find_frame();
		int n;
		bit hit;
		bit ok;
		n = 0;
		hit = 0;
		if (shadow_mode == tocf_pkg::MODE_SEQ) begin
			for (int p = 0; p + shadow_tlen <= shadow_fill && !hit; p++) begin
				ok = 1;
				for (int i = 0; i < shadow_tlen; i++)
					if (shadow_store[(shadow_rp + p + i) % DEPTH] != shadow_term[8*i +: 8])
						ok = 0;
				if (ok) begin
					hit = 1;
					n = p + shadow_tlen;
				end
			end
		end else if (shadow_mode == tocf_pkg::MODE_COUNT) begin
			if (shadow_fill >= shadow_cnt) begin
				hit = 1;
				n = shadow_cnt;
			end
		end else if (shadow_mode == tocf_pkg::MODE_ANY) begin
			if (shadow_fill > 0) begin
				hit = 1;
				n = shadow_fill;
			end
		end
		if (!hit)
			return;
		shadow_mode = tocf_pkg::MODE_UNSET;
		shadow_term = '0;
		shadow_tlen = 0;
		shadow_cnt = 0;
		push_frame(n);
	endfunction

	function automatic void predict_frames(tocf_pkg::cmd_t c);
		tocf_pkg::res_t r;
		case (c.action)
			tocf_pkg::ACT_FEED: begin
				if (shadow_fill >= DEPTH) begin
					r = '0;
					r.last = 1'b1;
					r.overflow = 1'b1;
					frame_expect.push_back(r);
				end else begin
					shadow_store[(shadow_rp + shadow_fill) % DEPTH] = c.data_byte;
					shadow_fill++;
					find_frame();
				end
			end
			tocf_pkg::ACT_SET: begin
				if (c.term_kind == tocf_pkg::KIND_SEQ) begin
					shadow_mode = tocf_pkg::MODE_SEQ;
					shadow_term = c.term_value;
					shadow_tlen = (int'(c.term_len) > MAX_TERM) ? MAX_TERM : int'(c.term_len);
				end else if (c.term_kind == tocf_pkg::KIND_COUNT) begin
					shadow_mode = tocf_pkg::MODE_COUNT;
					shadow_cnt = int'(c.term_count);
				end else begin
					shadow_mode = tocf_pkg::MODE_ANY;
				end
			end
			tocf_pkg::ACT_CLEAR: begin
				shadow_mode = tocf_pkg::MODE_UNSET;
				shadow_term = '0;
				shadow_tlen = 0;
				shadow_cnt = 0;
			end
			tocf_pkg::ACT_CHECK: find_frame();
			tocf_pkg::ACT_POP: if (shadow_fill > 0) push_frame(shadow_fill);
			default: ;
		endcase
	endfunction

	// request driver
	int no_idle_from = 150, no_idle_to = 240;
	always @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			predict_frames(cmd);
			accepted++;
		end
		if (arst_n && (!cmd_valid || !cmd_stall)) begin
			if (pending_cmds.size() > 0 && (($urandom_range(99) >= 8)
					|| (accepted >= no_idle_from && accepted < no_idle_to))) begin
				cmd <= pending_cmds.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with one long hold-off and a stall-free stretch
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (!hold_done && accepted >= 40) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			res_stall <= 1'b1;
		end else if (accepted >= 260 && accepted < 340) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(99) < 8);
		end
	end

	// result monitor
	always @(posedge clk) begin
		tocf_pkg::res_t e;
		if (res_valid && !res_stall) begin
			got_results++;
			if (frame_expect.size() == 0) begin
				$error("unexpected result %h", res);
				errors++;
			end else begin
				e = frame_expect.pop_front();
				if (res.frame_byte !== e.frame_byte && !e.empty_frame && !e.overflow) begin
					$error("frame_byte exp %h got %h", e.frame_byte, res.frame_byte);
					errors++;
				end
				if (res.last !== e.last) begin
					$error("last exp %b got %b", e.last, res.last);
					errors++;
				end
				if (res.empty_frame !== e.empty_frame) begin
					$error("empty_frame exp %b got %b", e.empty_frame, res.empty_frame);
					errors++;
				end
				if (res.overflow !== e.overflow) begin
					$error("overflow exp %b got %b", e.overflow, res.overflow);
					errors++;
				end
				if (e.last && !e.overflow) frames_seen++;
				if (e.overflow) overflows_seen++;
				if (e.empty_frame) empties_seen++;
			end
		end
	end

	function automatic void add_req(logic [2:0] act, logic [7:0] b = 8'h00,
			logic [1:0] kind = tocf_pkg::KIND_SEQ, logic [63:0] val = '0,
			logic [3:0] len = 4'd0, logic [6:0] cnt = 7'd0);
		tocf_pkg::cmd_t c;
		c.action = act;
		c.data_byte = b;
		c.term_kind = kind;
		c.term_value = val;
		c.term_len = len;
		c.term_count = cnt;
		pending_cmds.push_back(c);
	endfunction

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(3))
			0: return 8'h0d;
			1: return 8'h0a;
			2: return 8'h55;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic tocf_pkg::cmd_t noise_req();
		tocf_pkg::cmd_t c;
		c.action = 3'($urandom_range(7));
		c.data_byte = 8'($urandom_range(255));
		c.term_kind = 2'($urandom_range(3));
		c.term_value = {$urandom(), $urandom()};
		c.term_len = 4'($urandom_range(15));
		c.term_count = 7'($urandom_range(64));
		return c;
	endfunction

	initial begin
		logic [63:0] tv;
		int tl, nb;
		// directed: empty terminators, sequences, count, any, odd codes
		add_req(tocf_pkg::ACT_SET, 8'h00, tocf_pkg::KIND_SEQ, 64'hffff_ffff_ffff_ffff, 4'd0);
		add_req(tocf_pkg::ACT_CHECK);
		add_req(tocf_pkg::ACT_SET, 8'h00, tocf_pkg::KIND_COUNT, '0, 4'd0, 7'd0);
		add_req(tocf_pkg::ACT_POP);
		add_req(tocf_pkg::ACT_CHECK);
		add_req(tocf_pkg::ACT_SET, 8'h00, tocf_pkg::KIND_SEQ, 64'h0000_0000_0000_0a0d, 4'd2);
		add_req(tocf_pkg::ACT_FEED, 8'hff);
		add_req(tocf_pkg::ACT_FEED, 8'h0d);
		add_req(tocf_pkg::ACT_FEED, 8'h0a);
		add_req(tocf_pkg::ACT_SET, 8'h00, tocf_pkg::KIND_SEQ, 64'h8000_0000_0000_0001, 4'd15);
		add_req(tocf_pkg::ACT_FEED, 8'h00);
		add_req(tocf_pkg::ACT_CLEAR);
		add_req(tocf_pkg::ACT_SET, 8'h00, tocf_pkg::KIND_COUNT, '0, 4'd0, 7'd64);
		for (int i = 0; i < 66; i++)
			add_req(tocf_pkg::ACT_FEED, i[7:0] ^ 8'ha5);
		add_req(tocf_pkg::ACT_SET, 8'h00, 2'd2);
		add_req(tocf_pkg::ACT_FEED, 8'h11);
		add_req(tocf_pkg::ACT_SET, 8'h00, 2'd3);
		add_req(tocf_pkg::ACT_CHECK);
		add_req(3'd5);
		add_req(3'd6);
		add_req(3'd7);
		add_req(tocf_pkg::ACT_FEED, 8'h42);
		add_req(tocf_pkg::ACT_POP);
		// random: mostly arm-then-feed sequences, some noise and overflow
		while (pending_cmds.size() + accepted < 370) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					tl = $urandom_range(8);
					tv = {$urandom(), $urandom()};
					for (int i = 0; i < tl; i++)
						tv[8*i +: 8] = pick_byte();
					add_req(tocf_pkg::ACT_SET, 8'h00, tocf_pkg::KIND_SEQ, tv, tl[3:0]);
					nb = $urandom_range(6);
					for (int i = 0; i < nb; i++)
						add_req(tocf_pkg::ACT_FEED, pick_byte());
					if ($urandom_range(3) != 0)
						for (int i = 0; i < tl; i++)
							add_req(tocf_pkg::ACT_FEED, tv[8*i +: 8]);
					else
						add_req(tocf_pkg::ACT_CHECK);
				end
				4, 5: begin
					add_req(tocf_pkg::ACT_SET, 8'h00, tocf_pkg::KIND_COUNT, '0, 4'd0,
						7'($urandom_range(8)));
					nb = $urandom_range(8);
					for (int i = 0; i < nb; i++)
						add_req(tocf_pkg::ACT_FEED, 8'($urandom_range(255)));
				end
				6: begin
					add_req(tocf_pkg::ACT_SET, 8'h00, 2'(2 + $urandom_range(1)));
					add_req(tocf_pkg::ACT_FEED, 8'($urandom_range(255)));
				end
				7: add_req(tocf_pkg::ACT_POP);
				8: pending_cmds.push_back(noise_req());
				default: begin
					if ($urandom_range(9) == 0) begin
						add_req(tocf_pkg::ACT_CLEAR);
						for (int i = 0; i < 66; i++)
							add_req(tocf_pkg::ACT_FEED, 8'($urandom_range(255)));
						add_req(tocf_pkg::ACT_POP);
					end else begin
						add_req(tocf_pkg::ACT_CHECK);
					end
				end
			endcase
		end
		gen_done = 1;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		wait (gen_done);
		while (pending_cmds.size() > 0 || cmd_valid || frame_expect.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (frame_expect.size() > 0) begin
			$error("%0d results never arrived", frame_expect.size());
			errors++;
		end
		$display("covered %0d requests, %0d results: %0d frames, %0d empty, %0d overflow",
			accepted, got_results, frames_seen, empties_seen, overflows_seen);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
